FILE: src/mpd_pkg.sv
`default_nettype none

package mpd_pkg;

  typedef enum logic [5:0] {
    PH_HDR   = 6'b000001,
    PH_RLEN  = 6'b000010,
    PH_TLEN  = 6'b000100,
    PH_TOPIC = 6'b001000,
    PH_PID   = 6'b010000,
    PH_PAY   = 6'b100000
  } phase_t;

  localparam logic [2:0] CLS_HDR   = 3'd0;
  localparam logic [2:0] CLS_RLEN  = 3'd1;
  localparam logic [2:0] CLS_TLEN  = 3'd2;
  localparam logic [2:0] CLS_TOPIC = 3'd3;
  localparam logic [2:0] CLS_PID   = 3'd4;
  localparam logic [2:0] CLS_PAY   = 3'd5;

  localparam int QOS_LSB = 1;
  localparam int QOS_MSB = 2;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  byte_value;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [15:0] topic_len;
    logic [15:0] packet_ident;
    logic        last_of_packet;
    logic        malformed;
  } res_t;

endpackage

`default_nettype wire

FILE: src/mpd_if.sv
`default_nettype none

interface mpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface mpd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_class;
  logic [7:0]  byte_value;
  logic [3:0]  packet_type;
  logic [3:0]  header_flags;
  logic [15:0] topic_len;
  logic [15:0] packet_ident;
  logic        last_of_packet;
  logic        malformed;

  modport source (
    output valid, output byte_class, output byte_value, output packet_type,
    output header_flags, output topic_len, output packet_ident,
    output last_of_packet, output malformed, input ready
  );
  modport sink (
    input valid, input byte_class, input byte_value, input packet_type,
    input header_flags, input topic_len, input packet_ident,
    input last_of_packet, input malformed, output ready
  );
endinterface

`default_nettype wire

FILE: src/mpd_in_stage.sv
`default_nettype none

module mpd_in_stage (
  input  wire logic   clk,
  input  wire logic   rst,
  mpd_in_if.sink      rx,
  input  wire logic   take,
  output logic        valid,
  output logic [7:0]  data
);

  assign rx.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.ready) begin
      valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      data <= rx.in_byte;
    end
  end

endmodule

`default_nettype wire

FILE: src/mpd_parse.sv
`default_nettype none

module mpd_parse (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic [7:0]  data,
  output mpd_pkg::res_t    res
);

  mpd_pkg::phase_t phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] topic_left, topic_left_next;
  logic [15:0] topic_length_reg, topic_length_reg_next;
  logic [15:0] ident_reg, ident_reg_next;
  logic [3:0]  type_reg, type_reg_next;
  logic [3:0]  flags_reg, flags_reg_next;
  logic        id_byte_count, id_byte_count_next;

  logic [7:0]  bl_dec;
  logic [15:0] tl_dec;
  logic [15:0] tlen_word;
  logic        qos;
  logic [15:0] adv_left;
  mpd_pkg::phase_t adv_phase;
  logic [2:0]  cls;
  logic        last;
  logic        mal;

  assign bl_dec    = bytes_left - 8'd1;
  assign tl_dec    = topic_left - 16'd1;
  assign tlen_word = {topic_left[7:0], data};
  assign qos       = flags_reg[mpd_pkg::QOS_MSB:mpd_pkg::QOS_LSB] != 2'b00;

  // After the topic length or a topic byte, pick the following field.
  always_comb begin
    adv_left = (phase == mpd_pkg::PH_TOPIC) ? tl_dec : tlen_word;
    if (adv_left != 16'd0) begin
      adv_phase = mpd_pkg::PH_TOPIC;
    end else if (qos) begin
      adv_phase = mpd_pkg::PH_PID;
    end else begin
      adv_phase = mpd_pkg::PH_PAY;
    end
  end

  always_comb begin
    phase_next            = phase;
    bytes_left_next       = bytes_left;
    topic_left_next       = topic_left;
    topic_length_reg_next = topic_length_reg;
    ident_reg_next        = ident_reg;
    type_reg_next         = type_reg;
    flags_reg_next        = flags_reg;
    id_byte_count_next    = id_byte_count;
    cls                   = mpd_pkg::CLS_HDR;
    last                  = 1'b0;
    mal                   = 1'b0;
    // The header phase and any illegal code both take the default arm.
    unique case (phase)
      mpd_pkg::PH_RLEN: begin
        cls             = mpd_pkg::CLS_RLEN;
        bytes_left_next = data;
        if (data == 8'd0) begin
          last       = 1'b1;
          mal        = 1'b1;
          phase_next = mpd_pkg::PH_HDR;
        end else begin
          phase_next = mpd_pkg::PH_TLEN;
        end
      end
      mpd_pkg::PH_TLEN, mpd_pkg::PH_PID: begin
        cls             = (phase == mpd_pkg::PH_TLEN) ? mpd_pkg::CLS_TLEN
                                                      : mpd_pkg::CLS_PID;
        bytes_left_next = bl_dec;
        if (!id_byte_count) begin
          topic_left_next    = {8'd0, data};
          id_byte_count_next = 1'b1;
          if (bl_dec == 8'd0) begin
            last       = 1'b1;
            mal        = 1'b1;
            phase_next = mpd_pkg::PH_HDR;
          end
        end else if (phase == mpd_pkg::PH_TLEN) begin
          topic_length_reg_next = tlen_word;
          topic_left_next       = tlen_word;
          id_byte_count_next    = 1'b0;
          if (bl_dec == 8'd0) begin
            last       = 1'b1;
            mal        = adv_phase != mpd_pkg::PH_PAY;
            phase_next = mpd_pkg::PH_HDR;
          end else begin
            phase_next = adv_phase;
          end
        end else begin
          ident_reg_next     = tlen_word;
          topic_left_next    = 16'd0;
          id_byte_count_next = 1'b0;
          if (bl_dec == 8'd0) begin
            last       = 1'b1;
            phase_next = mpd_pkg::PH_HDR;
          end else begin
            phase_next = mpd_pkg::PH_PAY;
          end
        end
      end
      mpd_pkg::PH_TOPIC: begin
        cls             = mpd_pkg::CLS_TOPIC;
        bytes_left_next = bl_dec;
        topic_left_next = tl_dec;
        if (bl_dec == 8'd0) begin
          last       = 1'b1;
          mal        = adv_phase != mpd_pkg::PH_PAY;
          phase_next = mpd_pkg::PH_HDR;
        end else begin
          phase_next = adv_phase;
        end
      end
      mpd_pkg::PH_PAY: begin
        cls             = mpd_pkg::CLS_PAY;
        bytes_left_next = bl_dec;
        if (bl_dec == 8'd0) begin
          last       = 1'b1;
          phase_next = mpd_pkg::PH_HDR;
        end
      end
      default: begin
        cls                   = mpd_pkg::CLS_HDR;
        type_reg_next         = data[7:4];
        flags_reg_next        = data[3:0];
        topic_length_reg_next = 16'd0;
        ident_reg_next        = 16'd0;
        topic_left_next       = 16'd0;
        id_byte_count_next    = 1'b0;
        bytes_left_next       = 8'd0;
        phase_next            = mpd_pkg::PH_RLEN;
      end
    endcase
  end

  always_comb begin
    res.byte_class     = cls;
    res.byte_value     = data;
    res.packet_type    = type_reg_next;
    res.header_flags   = flags_reg_next;
    res.topic_len      = topic_length_reg_next;
    res.packet_ident   = ident_reg_next;
    res.last_of_packet = last;
    res.malformed      = mal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= mpd_pkg::PH_HDR;
      bytes_left       <= 8'd0;
      topic_left       <= 16'd0;
      topic_length_reg <= 16'd0;
      ident_reg        <= 16'd0;
      type_reg         <= 4'd0;
      flags_reg        <= 4'd0;
      id_byte_count    <= 1'b0;
    end else if (load) begin
      phase            <= phase_next;
      bytes_left       <= bytes_left_next;
      topic_left       <= topic_left_next;
      topic_length_reg <= topic_length_reg_next;
      ident_reg        <= ident_reg_next;
      type_reg         <= type_reg_next;
      flags_reg        <= flags_reg_next;
      id_byte_count    <= id_byte_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/mpd_out_stage.sv
`default_nettype none

module mpd_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire mpd_pkg::res_t res,
  output logic               free,
  mpd_out_if.source          tx
);

  mpd_pkg::res_t held;

  assign free = !tx.valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (free) begin
      tx.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign tx.byte_class     = held.byte_class;
  assign tx.byte_value     = held.byte_value;
  assign tx.packet_type    = held.packet_type;
  assign tx.header_flags   = held.header_flags;
  assign tx.topic_len      = held.topic_len;
  assign tx.packet_ident   = held.packet_ident;
  assign tx.last_of_packet = held.last_of_packet;
  assign tx.malformed      = held.malformed;

endmodule

`default_nettype wire

FILE: src/mqtt_publish_deframer.sv
`default_nettype none

// Publish packet deframer: every byte taken on rx comes out on tx with its
// role in the packet, the header fields and the topic length and packet
// identifier as far as they are known. One byte is taken per clock cycle
// when tx keeps up. A byte taken is registered in the input stage, passes
// through the parser and is registered in the output stage once that stage
// is free; the rate is set by the parser state, updated with each byte loaded.
module mqtt_publish_deframer (
  input  wire logic clk,
  input  wire logic rst,
  mpd_in_if.sink    rx,
  mpd_out_if.source tx
);

  logic          s1_valid;
  logic [7:0]    s1_data;
  logic          out_free;
  logic          load;
  mpd_pkg::res_t res;

  assign load = s1_valid && out_free;

  mpd_in_stage u_in (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (load),
    .valid (s1_valid),
    .data  (s1_data)
  );

  mpd_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .data (s1_data),
    .res  (res)
  );

  mpd_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .res  (res),
    .free (out_free),
    .tx   (tx)
  );

endmodule

`default_nettype wire

FILE: src/mpd_checker.sv
`default_nettype none

module mpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        tx_valid,
  input wire logic        tx_ready,
  input wire logic [2:0]  byte_class,
  input wire logic [7:0]  byte_value,
  input wire logic [15:0] topic_len,
  input wire logic [15:0] packet_ident,
  input wire logic        last_of_packet,
  input wire logic        malformed
);

  a_mal_ends: assert property (@(posedge clk) disable iff (rst)
    tx_valid && malformed |-> last_of_packet)
    else $error("malformed beat does not end its packet");

  a_class_range: assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> byte_class <= mpd_pkg::CLS_PAY)
    else $error("byte class out of range");

  a_hdr_fresh: assert property (@(posedge clk) disable iff (rst)
    tx_valid && byte_class == mpd_pkg::CLS_HDR
      |-> topic_len == 16'd0 && packet_ident == 16'd0 && !last_of_packet)
    else $error("header beat carries stale fields");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    tx_valid && byte_class == mpd_pkg::CLS_RLEN && byte_value == 8'd0
      |-> last_of_packet && malformed)
    else $error("zero remaining length not flagged");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(byte_value) && $stable(byte_class))
    else $error("stalled output beat changed");

endmodule

bind mqtt_publish_deframer mpd_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .tx_valid       (tx.valid),
  .tx_ready       (tx.ready),
  .byte_class     (tx.byte_class),
  .byte_value     (tx.byte_value),
  .topic_len      (tx.topic_len),
  .packet_ident   (tx.packet_ident),
  .last_of_packet (tx.last_of_packet),
  .malformed      (tx.malformed)
);

`default_nettype wire
